>>> design/lpht_pkg.sv
// Shared constants and types for the linear-probe hash table.
`default_nettype none
package lpht_pkg;
    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int MAX_NODES_DEF   = 512;
    localparam int PROBE_STEP_DEF  = 1;

    localparam int KEY_W     = 31;
    localparam int HSIZE_W   = 11;
    localparam int IDBASE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int NODEID_W  = 17;
    localparam int SLOTIDX_W = 10;
    localparam int DIV_CNT_W = 5;

    localparam logic [HSIZE_W-1:0] HSIZE_RST = 11'd1024;

    localparam logic CFG_HASH_SIZE = 1'b0;
    localparam logic CFG_ID_BASE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EXISTS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic               start;
        logic [KEY_W-1:0]   dividend;
    } t_div_req;
endpackage
`default_nettype wire

>>> design/lpht_mod.sv
// Bit-serial restoring modulo unit: remainder of a 31-bit value by a run-time divisor.
`default_nettype none
module lpht_mod #(
    parameter int DVS_W = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lpht_pkg::t_div_req    i_req,
    input  wire logic [DVS_W-1:0]      i_divisor,
    output logic                       o_done,
    output logic [DVS_W-1:0]           o_rem
);
    import lpht_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_dvd;
    logic [DVS_W-1:0]     r_rem;
    logic                 r_done;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[KEY_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = trial - {1'b0, i_divisor};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem[DVS_W-1:0];
                r_dvd  <= {r_dvd[KEY_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == DIV_CNT_W'(KEY_W - 1));
                if (r_cnt == DIV_CNT_W'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

>>> design/linear_probe_hash_table.sv
// Top level: open-addressing key-to-id table with linear probing.
// Sequence: two modulo runs (key, probe step) in the shared bit-serial unit,
// then the states S_RD, S_SLOT and S_KEY per probed slot (S_SLOT ends the probe
// at an empty slot) and S_FIN to load the output register.
// Throughput: one transaction at a time; the next is taken once the sequencer
// is back in idle, while the previous result may still wait at the output.
// Reset: synchronous; a clearing pass over all TABLE_SLOTS slots empties the slot store.
`default_nettype none
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_NODES   = lpht_pkg::MAX_NODES_DEF,
    parameter int PROBE_STEP  = lpht_pkg::PROBE_STEP_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [lpht_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_op,
    input  wire logic [lpht_pkg::KEY_W-1:0]      i_key,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic [lpht_pkg::NODEID_W-1:0]        o_node_id,
    output logic [lpht_pkg::SLOTIDX_W-1:0]       o_slot_index,
    output logic                                 o_out_of_sync
);
    import lpht_pkg::*;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int HS_W   = $clog2(TABLE_SLOTS + 1);
    localparam int LID_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIVK, S_DIVS, S_RD, S_SLOT, S_KEY, S_FIN
    } t_state;

    t_state              r_state;
    logic [HSIZE_W-1:0]  r_hash_size;
    logic [IDBASE_W-1:0] r_id_base;
    logic [SLOT_W-1:0]   r_clr;
    logic                r_op;
    logic [KEY_W-1:0]    r_key;
    logic [SLOT_W-1:0]   r_pos;
    logic [SLOT_W-1:0]   r_step;
    logic [HS_W-1:0]     r_cnt;
    logic [CNT_W-1:0]    r_nodes;
    logic                r_sync;
    logic                r_do_ins;
    t_status             r_res_st;
    logic [NODEID_W-1:0] r_res_id;
    logic [SLOT_W-1:0]   r_res_slot;

    logic                r_out_valid;
    t_status             r_out_st;
    logic [NODEID_W-1:0] r_out_id;
    logic [SLOTIDX_W-1:0] r_out_slot;
    logic                r_out_sync;

    // slot store: {used, local id}; key store indexed by local id
    logic [LID_W:0]      slot_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]    key_mem  [MAX_NODES];
    logic [LID_W:0]      r_slot_q;
    logic [KEY_W-1:0]    r_key_q;

    logic                slot_we;
    logic [SLOT_W-1:0]   slot_wa;
    logic [LID_W:0]      slot_wd;

    logic [HS_W-1:0]     hs;
    logic [HS_W:0]       pos_sum;
    logic [SLOT_W-1:0]   pos_next;
    logic                last_probe;
    logic                lid_ok;
    logic [NODEID_W-1:0] found_id;
    logic                can_ins;

    t_div_req            div_req;
    logic                div_done;
    logic [HS_W-1:0]     div_rem;

    // effective size: 0 acts as 1, anything above the store acts as the store
    always_comb begin
        if (r_hash_size == '0) begin
            hs = HS_W'(1);
        end else if (32'(r_hash_size) > 32'(TABLE_SLOTS)) begin
            hs = HS_W'(TABLE_SLOTS);
        end else begin
            hs = HS_W'(r_hash_size);
        end
    end

    always_comb begin
        pos_sum = (HS_W+1)'(r_pos) + (HS_W+1)'(r_step);
        if (pos_sum >= {1'b0, hs}) begin
            pos_next = SLOT_W'(pos_sum - {1'b0, hs});
        end else begin
            pos_next = SLOT_W'(pos_sum);
        end
    end

    assign last_probe = ((HS_W+1)'(r_cnt) + 1'b1) == {1'b0, hs};
    assign lid_ok     = 32'(r_slot_q[LID_W-1:0]) < 32'(MAX_NODES);
    assign found_id   = NODEID_W'(r_id_base) + NODEID_W'(r_slot_q[LID_W-1:0]);
    assign can_ins    = !r_op && (32'(r_nodes) < 32'(MAX_NODES));

    assign div_req.start    = (r_state == S_IDLE && i_in_valid) ||
                              (r_state == S_DIVK && div_done);
    assign div_req.dividend = (r_state == S_IDLE) ? i_key : KEY_W'(PROBE_STEP);

    lpht_mod #(.DVS_W(HS_W)) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (hs),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    always_comb begin
        slot_we = 1'b0;
        slot_wa = r_clr;
        slot_wd = '0;
        if (r_state == S_CLEAR) begin
            slot_we = 1'b1;
        end else if (r_state == S_FIN && (!r_out_valid || i_out_ready) && r_do_ins) begin
            slot_we = 1'b1;
            slot_wa = r_res_slot;
            slot_wd = {1'b1, LID_W'(r_nodes)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_q <= slot_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_out_valid || i_out_ready) && r_do_ins) begin
            key_mem[LID_W'(r_nodes)] <= r_key;
        end
        r_key_q <= key_mem[r_slot_q[LID_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_size <= HSIZE_RST;
            r_id_base   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HASH_SIZE: r_hash_size <= i_cfg_data[HSIZE_W-1:0];
                CFG_ID_BASE:   r_id_base   <= i_cfg_data[IDBASE_W-1:0];
                default:       r_id_base   <= r_id_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_nodes     <= '0;
            r_sync      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_sync  <= 1'b0;
        end else begin
            // S_FIN reloads the output register itself when it is taken
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == TABLE_SLOTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_key   <= i_key;
                        r_state <= S_DIVK;
                    end
                end
                S_DIVK: begin
                    if (div_done) begin
                        r_pos   <= SLOT_W'(div_rem);
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if (div_done) begin
                        r_step  <= SLOT_W'(div_rem);
                        r_cnt   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_SLOT;
                S_SLOT: begin
                    if (!r_slot_q[LID_W]) begin
                        // empty slot ends the probe: miss, or the place to insert
                        r_do_ins   <= can_ins;
                        r_res_st   <= can_ins ? ST_OK : (r_op ? ST_NOTFOUND : ST_FULL);
                        r_res_slot <= can_ins ? r_pos : '0;
                        r_res_id   <= can_ins ?
                                      NODEID_W'(r_id_base) + NODEID_W'(r_nodes) : '0;
                        r_state    <= S_FIN;
                    end else begin
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    if (lid_ok && r_key_q == r_key) begin
                        r_do_ins   <= 1'b0;
                        r_res_st   <= r_op ? ST_OK : ST_EXISTS;
                        r_res_slot <= r_pos;
                        r_res_id   <= found_id;
                        r_state    <= S_FIN;
                    end else if (last_probe) begin
                        r_do_ins   <= 1'b0;
                        r_res_st   <= r_op ? ST_NOTFOUND : ST_FULL;
                        r_res_slot <= '0;
                        r_res_id   <= '0;
                        r_state    <= S_FIN;
                    end else begin
                        r_pos   <= pos_next;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_st    <= r_res_st;
                        r_out_id    <= r_res_id;
                        r_out_slot  <= SLOTIDX_W'(r_res_slot);
                        if (r_do_ins) begin
                            r_nodes <= r_nodes + 1'b1;
                            if (r_nodes != '0) begin
                                r_sync     <= 1'b1;
                                r_out_sync <= 1'b1;
                            end else begin
                                r_out_sync <= r_sync;
                            end
                        end else begin
                            r_out_sync <= r_sync;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_st;
    assign o_node_id     = r_out_id;
    assign o_slot_index  = r_out_slot;
    assign o_out_of_sync = r_out_sync;
endmodule
`default_nettype wire

>>> design/lpht_chk.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
module lpht_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_status,
    input wire logic [16:0] o_node_id,
    input wire logic [9:0]  o_slot_index,
    input wire logic        o_out_of_sync
);
    import lpht_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
                                        && $stable(o_node_id))
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("new transaction taken while one is in progress");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NOTFOUND || o_status == ST_FULL)
        |-> o_node_id == '0 && o_slot_index == '0)
        else $error("miss or full result carries an id or slot");

    a_sync_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(o_out_of_sync))
        else $error("out-of-sync flag cleared without reset");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block active straight after reset");
endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_node_id     (o_node_id),
    .o_slot_index  (o_slot_index),
    .o_out_of_sync (o_out_of_sync)
);
`default_nettype wire

>>> bench/linear_probe_hash_table_test.sv
// Self-checking bench for the linear-probe hash table: directed and random inserts and lookups.
module linear_probe_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        t_status              status;
        logic [NODEID_W-1:0]  node_id;
        logic [SLOTIDX_W-1:0] slot;
        logic                 oos;
    } t_answer;

    // Mirror of the table contents; predicts one answer per request.
    class table_scoreboard;
        bit                   slot_used [TABLE_SLOTS_DEF];
        logic [8:0]           slot_lid  [TABLE_SLOTS_DEF];
        logic [KEY_W-1:0]     key_of_id [MAX_NODES_DEF];
        int unsigned          node_count;
        bit                   sync_lost;
        logic [HSIZE_W-1:0]   hash_size;
        logic [IDBASE_W-1:0]  id_base;
        t_answer              awaited [$];
        int                   errors;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            node_count = 0;
            sync_lost  = 1'b0;
            hash_size  = HSIZE_RST;
            id_base    = '0;
            errors     = 0;
        endfunction

        function int unsigned span();
            int unsigned s;
            s = hash_size;
            if (s == 0) s = 1;
            if (s > TABLE_SLOTS_DEF) s = TABLE_SLOTS_DEF;
            return s;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key);
            int unsigned hs, step, pos, lid, free_pos;
            bit          hit, got_free;
            t_answer     a;
            hs = span();
            step = PROBE_STEP_DEF % hs;
            hit = 0;
            got_free = 0;
            lid = 0;
            free_pos = 0;
            pos = key % hs;
            for (int unsigned i = 0; i < hs; i++) begin
                if (!slot_used[pos]) break;
                if (slot_lid[pos] < MAX_NODES_DEF && key_of_id[slot_lid[pos]] == key) begin
                    hit = 1;
                    lid = slot_lid[pos];
                    break;
                end
                pos = (pos + step) % hs;
            end
            a.node_id = '0;
            a.slot = '0;
            if (hit) begin
                a.status = op ? ST_OK : ST_EXISTS;
                a.node_id = NODEID_W'(id_base + lid);
                a.slot = SLOTIDX_W'(pos);
            end else if (op) begin
                a.status = ST_NOTFOUND;
            end else begin
                if (node_count < MAX_NODES_DEF) begin
                    pos = key % hs;
                    for (int unsigned i = 0; i < hs; i++) begin
                        if (!slot_used[pos]) begin
                            got_free = 1;
                            free_pos = pos;
                            break;
                        end
                        pos = (pos + step) % hs;
                    end
                end
                if (!got_free) begin
                    a.status = ST_FULL;
                end else begin
                    lid = node_count;
                    key_of_id[lid] = key;
                    slot_used[free_pos] = 1'b1;
                    slot_lid[free_pos] = 9'(lid);
                    node_count++;
                    if (node_count != 1) sync_lost = 1'b1;
                    a.status = ST_OK;
                    a.node_id = NODEID_W'(id_base + lid);
                    a.slot = SLOTIDX_W'(free_pos);
                end
            end
            a.oos = sync_lost;
            awaited.push_back(a);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [NODEID_W-1:0] id,
                          logic [SLOTIDX_W-1:0] sl, logic oos);
            t_answer a;
            if (awaited.size() == 0) begin
                report("unexpected transaction", 1, 0);
            end else begin
                a = awaited.pop_front();
                if (st !== a.status) report("status", st, a.status);
                if (id !== a.node_id) report("node_id", id, a.node_id);
                if (sl !== a.slot) report("slot_index", sl, a.slot);
                if (oos !== a.oos) report("out_of_sync", oos, a.oos);
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_idx = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_op = 1'b0;
    logic [KEY_W-1:0]     i_key = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_status;
    logic [NODEID_W-1:0]  o_node_id;
    logic [SLOTIDX_W-1:0] o_slot_index;
    logic                 o_out_of_sync;

    linear_probe_hash_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_op(i_op), .i_key(i_key),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_status(o_status),
        .o_node_id(o_node_id), .o_slot_index(o_slot_index), .o_out_of_sync(o_out_of_sync)
    );

    table_scoreboard  sb = new();
    bit               quiet = 0;
    bit               hold_req = 0;
    int               cycles = 0;
    logic [KEY_W-1:0] key_pool [$];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Transaction monitor on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_request(i_op, i_key);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_node_id, o_slot_index, o_out_of_sync);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                stall_left = 399;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after acceptance.
    task send(logic op, logic [KEY_W-1:0] key);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_key <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == 1'b0) key_pool.push_back(key);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task write_reg(logic idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HASH_SIZE) sb.hash_size = data[HSIZE_W-1:0];
        else sb.id_base = data[IDBASE_W-1:0];
        @(negedge i_clk);
    endtask

    function logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 8)
            return KEY_W'($urandom_range(0, 63));
        else
            return KEY_W'($urandom());
    endfunction

    initial begin
        logic [CFG_W-1:0] hs_pick;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass of the slot store
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);

        // defaults: extremes of the key, duplicate, hit, miss
        send(1'b1, 31'd5);
        send(1'b0, 31'd0);
        send(1'b0, 31'h7FFF_FFFF);
        send(1'b0, 31'd0);
        send(1'b1, 31'h7FFF_FFFF);
        send(1'b1, 31'd0);
        send(1'b0, 31'd1024);
        send(1'b1, 31'd1024);
        send(1'b1, 31'd2048);
        drain();
        // one slot, largest id base: only slot 0 reachable
        write_reg(CFG_HASH_SIZE, 16'd1);
        write_reg(CFG_ID_BASE, 16'hFFFF);
        send(1'b1, 31'd0);
        send(1'b0, 31'd7);
        send(1'b1, 31'd7);
        drain();
        // zero acts as one slot
        write_reg(CFG_HASH_SIZE, 16'd0);
        send(1'b1, 31'd1024);
        send(1'b0, 31'd3);
        drain();
        // oversize acts as the full table; high data bits are dropped
        write_reg(CFG_HASH_SIZE, 16'hFFFF);
        write_reg(CFG_ID_BASE, 16'd0);
        send(1'b1, 31'h7FFF_FFFF);
        send(1'b0, 31'd2047);
        send(1'b1, 31'd1024);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case ($urandom_range(0, 4))
                0: hs_pick = CFG_W'($urandom_range(1, 4));
                1: hs_pick = 16'd1024;
                2: hs_pick = CFG_W'($urandom_range(1025, 2047));
                default: hs_pick = CFG_W'($urandom_range(2, 48));
            endcase
            write_reg(CFG_HASH_SIZE, hs_pick);
            write_reg(CFG_ID_BASE, (ph == 3) ? 16'hFFFF : CFG_W'($urandom_range(0, 65535)));
            if (ph == 6) quiet = 1;
            if (ph == 1) hold_req = 1;
            for (int n = 0; n < 100; n++) send(1'($urandom_range(0, 1)), pick_key());
            drain();
        end

        repeat (80) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
